FILE: rtl/sscp_pkg.sv
// shared widths, word types and arithmetic helpers for the segment closest-point pipeline
package sscp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int LIMIT_W     = 32;
  localparam int SEG_BITS    = 32;
  localparam int PARAM_W     = SEG_BITS + 1;
  localparam int DELTA_W     = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DELTA_W;
  localparam int DOT_W       = PROD_W + 2;
  localparam int HALF_W      = DOT_W / 2;
  localparam int WIDE_W      = 2 * DOT_W;
  localparam int DIV_W       = WIDE_W + 2;
  localparam int BQ_W        = HALF_W + PARAM_W;
  localparam int TN_W        = DOT_W + PARAM_W;
  localparam int PP_W        = DELTA_W + PARAM_W + 1;
  localparam int RND_W       = PP_W - SEG_BITS;
  localparam int PIPE_DEPTH  = 8 + 2 * (SEG_BITS + 1) + 4 + 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4295);
  localparam logic [PARAM_W-1:0] PARAM_ONE   = {1'b1, {SEG_BITS{1'b0}}};

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] p1;
    logic [2:0][COORD_WIDTH-1:0] p2;
    logic [2:0][DELTA_W-1:0]     d1;
    logic [2:0][DELTA_W-1:0]     d2;
  } geom_t;

  // side data carried through the first divider
  typedef struct packed {
    geom_t            g;
    logic             adeg;
    logic             edeg;
    logic [DOT_W-1:0] a;
    logic [DOT_W-1:0] e;
    logic [DOT_W-1:0] f;
    logic [DOT_W-1:0] negc;
    logic [DOT_W-1:0] bmc;
    logic [DOT_W-1:0] babs;
    logic             bneg;
  } sside_t;

  // side data carried through the second divider
  typedef struct packed {
    geom_t              g;
    logic               adeg;
    logic               edeg;
    logic               tneg;
    logic               tgt;
    logic [PARAM_W-1:0] q1;
  } tside_t;

  function automatic logic signed [PROD_W-1:0] mul_delta(logic signed [DELTA_W-1:0] x,
                                                         logic signed [DELTA_W-1:0] y);
    logic signed [PROD_W-1:0] xe;
    logic signed [PROD_W-1:0] ye;
    xe = PROD_W'(x);
    ye = PROD_W'(y);
    return xe * ye;
  endfunction

  function automatic logic signed [DOT_W-1:0] sum3(logic [2:0][PROD_W-1:0] p);
    logic signed [DOT_W-1:0] s0;
    logic signed [DOT_W-1:0] s1;
    logic signed [DOT_W-1:0] s2;
    s0 = DOT_W'($signed(p[0]));
    s1 = DOT_W'($signed(p[1]));
    s2 = DOT_W'($signed(p[2]));
    return s0 + s1 + s2;
  endfunction

  function automatic logic [DOT_W-1:0] abs_dot(logic signed [DOT_W-1:0] x);
    logic signed [DOT_W-1:0] n;
    n = -x;
    return x[DOT_W-1] ? n : x;
  endfunction

  function automatic logic [DOT_W-1:0] mul_half(logic [HALF_W-1:0] x, logic [HALF_W-1:0] y);
    logic [DOT_W-1:0] xe;
    logic [DOT_W-1:0] ye;
    xe = DOT_W'(x);
    ye = DOT_W'(y);
    return xe * ye;
  endfunction

  function automatic logic [BQ_W-1:0] mul_bq(logic [HALF_W-1:0] x, logic [PARAM_W-1:0] q);
    logic [BQ_W-1:0] xe;
    logic [BQ_W-1:0] qe;
    xe = BQ_W'(x);
    qe = BQ_W'(q);
    return xe * qe;
  endfunction

  function automatic logic signed [PP_W-1:0] mul_pt(logic signed [DELTA_W-1:0] d,
                                                    logic [PARAM_W-1:0] q);
    logic signed [PP_W-1:0] de;
    logic signed [PP_W-1:0] qe;
    de = PP_W'(d);
    qe = $signed(PP_W'(q));
    return de * qe;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat_coord(logic signed [RND_W-1:0] x);
    logic signed [RND_W-1:0] maxv;
    logic signed [RND_W-1:0] minv;
    maxv = $signed({{(RND_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    minv = -maxv - RND_W'(1);
    if (x > maxv) begin
      return maxv[COORD_WIDTH-1:0];
    end else if (x < minv) begin
      return minv[COORD_WIDTH-1:0];
    end else begin
      return x[COORD_WIDTH-1:0];
    end
  endfunction

endpackage

FILE: rtl/sscp_div.sv
// pipelined restoring divider giving clamp(num/den, 0, 1) as a fraction, one quotient bit per stage
module sscp_div import sscp_pkg::*; #(
  parameter int DW     = DIV_W,
  parameter int STEPS  = SEG_BITS,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DW-1:0]     num,
  input  logic [DW-1:0]     den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [STEPS:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld  [0:STEPS];
  logic [DW-1:0]     rem  [0:STEPS];
  logic [DW-1:0]     dsr  [0:STEPS];
  logic [STEPS-1:0]  qb   [0:STEPS];
  logic              fix  [0:STEPS];
  logic              fone [0:STEPS];
  logic [SIDE_W-1:0] sd   [0:STEPS];

  logic den_pos;
  logic num_pos;
  logic num_lt;

  assign den_pos = !den[DW-1] && (|den);
  assign num_pos = !num[DW-1] && (|num);
  assign num_lt  = $signed(num) < $signed(den);

  // entry: settle the trivial cases, the steps only matter for 0 < num < den
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0]  <= num;
    dsr[0]  <= den;
    qb[0]   <= '0;
    fix[0]  <= !(den_pos && num_pos && num_lt);
    fone[0] <= den_pos && num_pos;
    sd[0]   <= side_in;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [DW:0] sh;
    logic [DW:0] df;
    logic        ge;

    assign sh = {rem[k], 1'b0};
    assign df = sh - {1'b0, dsr[k]};
    assign ge = !df[DW];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1]  <= ge ? df[DW-1:0] : sh[DW-1:0];
      dsr[k+1]  <= dsr[k];
      qb[k+1]   <= {qb[k][STEPS-2:0], ge};
      fix[k+1]  <= fix[k];
      fone[k+1] <= fone[k];
      sd[k+1]   <= sd[k];
    end
  end

  assign out_valid = vld[STEPS];
  assign side_out  = sd[STEPS];
  assign quo = fix[STEPS] ? (fone[STEPS] ? {1'b1, {STEPS{1'b0}}} : '0)
                          : {1'b0, qb[STEPS]};

endmodule

FILE: rtl/segment_segment_closest_points.sv
// top level: closest points between two 3d segments, fully pipelined
// One segment pair is taken on every clock edge where start is high and busy is low; busy is
// high only during reset. Each pair gives one result, shown for a single cycle with done high;
// the pair passes a register chain of eight stages of dot products and wide products, two
// 33-stage dividers with one quotient bit per stage, four stages for the t numerator and three
// for the final points. A new pair may enter every cycle, and results leave in order at the
// same rate; the receiver cannot stall and must take each word in the cycle it shows.
// The degenerate limit is written over its own port; it must be written only while no pair
// is in flight, and the block itself does not enforce this.
module segment_segment_closest_points import sscp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] first_start_x,
  input  logic [COORD_WIDTH-1:0] first_start_y,
  input  logic [COORD_WIDTH-1:0] first_start_z,
  input  logic [COORD_WIDTH-1:0] first_end_x,
  input  logic [COORD_WIDTH-1:0] first_end_y,
  input  logic [COORD_WIDTH-1:0] first_end_z,
  input  logic [COORD_WIDTH-1:0] second_start_x,
  input  logic [COORD_WIDTH-1:0] second_start_y,
  input  logic [COORD_WIDTH-1:0] second_start_z,
  input  logic [COORD_WIDTH-1:0] second_end_x,
  input  logic [COORD_WIDTH-1:0] second_end_y,
  input  logic [COORD_WIDTH-1:0] second_end_z,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LIMIT_W-1:0]     cfg_data,
  output logic                   done,
  output logic [COORD_WIDTH-1:0] near_first_x,
  output logic [COORD_WIDTH-1:0] near_first_y,
  output logic [COORD_WIDTH-1:0] near_first_z,
  output logic [COORD_WIDTH-1:0] near_second_x,
  output logic [COORD_WIDTH-1:0] near_second_y,
  output logic [COORD_WIDTH-1:0] near_second_z
);

  logic [LIMIT_W-1:0] degenerate_limit;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      degenerate_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      degenerate_limit <= cfg_data;
    end
  end

  // stage 1: deltas
  logic [2:0][COORD_WIDTH-1:0] in_p1, in_q1, in_p2, in_q2;
  geom_t                   st1_g, st1_g_next;
  logic [2:0][DELTA_W-1:0] st1_r, st1_r_next;
  logic                    st1_v;

  assign in_p1 = {first_start_z, first_start_y, first_start_x};
  assign in_q1 = {first_end_z, first_end_y, first_end_x};
  assign in_p2 = {second_start_z, second_start_y, second_start_x};
  assign in_q2 = {second_end_z, second_end_y, second_end_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      st1_g_next.p1[i] = in_p1[i];
      st1_g_next.p2[i] = in_p2[i];
      st1_g_next.d1[i] = DELTA_W'($signed(in_q1[i])) - DELTA_W'($signed(in_p1[i]));
      st1_g_next.d2[i] = DELTA_W'($signed(in_q2[i])) - DELTA_W'($signed(in_p2[i]));
      st1_r_next[i]    = DELTA_W'($signed(in_p1[i])) - DELTA_W'($signed(in_p2[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_v <= 1'b0;
    end else begin
      st1_v <= start && !busy;
    end
    st1_g <= st1_g_next;
    st1_r <= st1_r_next;
  end

  // stage 2: coordinate products
  geom_t                  st2_g;
  logic [2:0][PROD_W-1:0] st2_aa, st2_ee, st2_bb, st2_cc, st2_ff;
  logic                   st2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_v <= 1'b0;
    end else begin
      st2_v <= st1_v;
    end
    st2_g <= st1_g;
    for (int i = 0; i < 3; i++) begin
      st2_aa[i] <= mul_delta(st1_g.d1[i], st1_g.d1[i]);
      st2_ee[i] <= mul_delta(st1_g.d2[i], st1_g.d2[i]);
      st2_bb[i] <= mul_delta(st1_g.d1[i], st1_g.d2[i]);
      st2_cc[i] <= mul_delta(st1_g.d1[i], st1_r[i]);
      st2_ff[i] <= mul_delta(st1_g.d2[i], st1_r[i]);
    end
  end

  // stage 3: dot products
  geom_t                   st3_g;
  logic signed [DOT_W-1:0] st3_a, st3_b, st3_c, st3_e, st3_f;
  logic                    st3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      st3_v <= 1'b0;
    end else begin
      st3_v <= st2_v;
    end
    st3_g <= st2_g;
    st3_a <= sum3(st2_aa);
    st3_b <= sum3(st2_bb);
    st3_c <= sum3(st2_cc);
    st3_e <= sum3(st2_ee);
    st3_f <= sum3(st2_ff);
  end

  // stage 4: degenerate tests, magnitudes for the wide products
  sside_t                  st4_sd, st4_sd_next;
  logic [DOT_W-1:0]        st4_cabs, st4_fabs;
  logic                    st4_cneg, st4_fneg, st4_v;
  logic signed [DOT_W-1:0] lim_ext;

  assign lim_ext = $signed(DOT_W'(degenerate_limit));

  always_comb begin
    st4_sd_next.g    = st3_g;
    st4_sd_next.adeg = st3_a <= lim_ext;
    st4_sd_next.edeg = st3_e <= lim_ext;
    st4_sd_next.a    = st3_a;
    st4_sd_next.e    = st3_e;
    st4_sd_next.f    = st3_f;
    st4_sd_next.negc = -st3_c;
    st4_sd_next.bmc  = st3_b - st3_c;
    st4_sd_next.babs = abs_dot(st3_b);
    st4_sd_next.bneg = st3_b[DOT_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st4_v <= 1'b0;
    end else begin
      st4_v <= st3_v;
    end
    st4_sd   <= st4_sd_next;
    st4_cabs <= abs_dot(st3_c);
    st4_cneg <= st3_c[DOT_W-1];
    st4_fabs <= abs_dot(st3_f);
    st4_fneg <= st3_f[DOT_W-1];
  end

  // stage 5: partial products of a*e, b*b, b*f and c*e
  logic [3:0][DOT_W-1:0]      opx, opy;
  logic [3:0]                 opneg;
  sside_t                     st5_sd;
  logic [3:0][3:0][DOT_W-1:0] st5_pp;
  logic [3:0]                 st5_neg;
  logic                       st5_v;

  always_comb begin
    opx[0] = st4_sd.a;    opy[0] = st4_sd.e;    opneg[0] = 1'b0;
    opx[1] = st4_sd.babs; opy[1] = st4_sd.babs; opneg[1] = 1'b0;
    opx[2] = st4_sd.babs; opy[2] = st4_fabs;    opneg[2] = st4_sd.bneg ^ st4_fneg;
    opx[3] = st4_cabs;    opy[3] = st4_sd.e;    opneg[3] = st4_cneg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st5_v <= 1'b0;
    end else begin
      st5_v <= st4_v;
    end
    st5_sd  <= st4_sd;
    st5_neg <= opneg;
    for (int k = 0; k < 4; k++) begin
      st5_pp[k][0] <= mul_half(opx[k][HALF_W-1:0], opy[k][HALF_W-1:0]);
      st5_pp[k][1] <= mul_half(opx[k][HALF_W-1:0], opy[k][DOT_W-1:HALF_W]);
      st5_pp[k][2] <= mul_half(opx[k][DOT_W-1:HALF_W], opy[k][HALF_W-1:0]);
      st5_pp[k][3] <= mul_half(opx[k][DOT_W-1:HALF_W], opy[k][DOT_W-1:HALF_W]);
    end
  end

  // stage 6: combine partials
  sside_t                 st6_sd;
  logic [3:0][WIDE_W-1:0] st6_mag;
  logic [3:0]             st6_neg;
  logic                   st6_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      st6_v <= 1'b0;
    end else begin
      st6_v <= st5_v;
    end
    st6_sd  <= st5_sd;
    st6_neg <= st5_neg;
    for (int k = 0; k < 4; k++) begin
      st6_mag[k] <= WIDE_W'(st5_pp[k][0])
                  + ((WIDE_W'(st5_pp[k][1]) + WIDE_W'(st5_pp[k][2])) << HALF_W)
                  + (WIDE_W'(st5_pp[k][3]) << DOT_W);
    end
  end

  // stage 7: apply signs
  sside_t                st7_sd;
  logic [3:0][DIV_W-1:0] st7_w;
  logic                  st7_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      st7_v <= 1'b0;
    end else begin
      st7_v <= st6_v;
    end
    st7_sd <= st6_sd;
    for (int k = 0; k < 4; k++) begin
      st7_w[k] <= st6_neg[k] ? -DIV_W'(st6_mag[k]) : DIV_W'(st6_mag[k]);
    end
  end

  // stage 8: denominator and s numerator
  sside_t           st8_sd;
  logic [DIV_W-1:0] st8_den, st8_num;
  logic             st8_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      st8_v <= 1'b0;
    end else begin
      st8_v <= st7_v;
    end
    st8_sd  <= st7_sd;
    st8_den <= st7_w[0] - st7_w[1];
    st8_num <= st7_w[2] - st7_w[3];
  end

  // first divider: s in the general case, t or s when one segment is a point
  logic [DIV_W-1:0]   dv1_num, dv1_den;
  logic               dv1_v;
  logic [PARAM_W-1:0] dv1_q;
  sside_t             dv1_sd;

  always_comb begin
    if (st8_sd.adeg && !st8_sd.edeg) begin
      dv1_num = DIV_W'($signed(st8_sd.f));
      dv1_den = DIV_W'($signed(st8_sd.e));
    end else if (st8_sd.edeg && !st8_sd.adeg) begin
      dv1_num = DIV_W'($signed(st8_sd.negc));
      dv1_den = DIV_W'($signed(st8_sd.a));
    end else begin
      dv1_num = st8_num;
      dv1_den = st8_den;
    end
  end

  sscp_div #(
    .DW     (DIV_W),
    .STEPS  (SEG_BITS),
    .SIDE_W ($bits(sside_t))
  ) u_div_s (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st8_v),
    .num       (dv1_num),
    .den       (dv1_den),
    .side_in   (st8_sd),
    .out_valid (dv1_v),
    .quo       (dv1_q),
    .side_out  (dv1_sd)
  );

  // t numerator: b*s + f scaled, then its range checks
  sside_t             m1_sd, m2_sd, m3_sd, m4_sd;
  logic [PARAM_W-1:0] m1_q, m2_q, m3_q, m4_q;
  logic [BQ_W-1:0]    m1_plo, m1_phi;
  logic [TN_W-1:0]    m2_bs;
  logic [DIV_W-1:0]   m3_tnum, m4_tnum;
  logic               m4_tneg, m4_tgt;
  logic               m1_v, m2_v, m3_v, m4_v;
  logic [DIV_W-1:0]   m3_fsh, m3_bs, m3_tden;

  assign m3_fsh  = DIV_W'($signed(m2_sd.f)) << SEG_BITS;
  assign m3_bs   = DIV_W'(m2_bs);
  assign m3_tden = DIV_W'($signed(m3_sd.e)) << SEG_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      m4_v <= 1'b0;
    end else begin
      m1_v <= dv1_v;
      m2_v <= m1_v;
      m3_v <= m2_v;
      m4_v <= m3_v;
    end
    m1_sd   <= dv1_sd;
    m1_q    <= dv1_q;
    m1_plo  <= mul_bq(dv1_sd.babs[HALF_W-1:0], dv1_q);
    m1_phi  <= mul_bq(dv1_sd.babs[DOT_W-1:HALF_W], dv1_q);
    m2_sd   <= m1_sd;
    m2_q    <= m1_q;
    m2_bs   <= TN_W'(m1_plo) + (TN_W'(m1_phi) << HALF_W);
    m3_sd   <= m2_sd;
    m3_q    <= m2_q;
    m3_tnum <= m2_sd.bneg ? m3_fsh - m3_bs : m3_fsh + m3_bs;
    m4_sd   <= m3_sd;
    m4_q    <= m3_q;
    m4_tnum <= m3_tnum;
    m4_tneg <= m3_tnum[DIV_W-1];
    m4_tgt  <= $signed(m3_tnum) > $signed(m3_tden);
  end

  // second divider: t, or s again when t was clamped
  logic [DIV_W-1:0]   dv2_num, dv2_den;
  logic               m4_gen;
  tside_t             dv2_sd_in, dv2_sd;
  logic               dv2_v;
  logic [PARAM_W-1:0] dv2_q;

  assign m4_gen = !m4_sd.adeg && !m4_sd.edeg;

  always_comb begin
    if (m4_gen && m4_tneg) begin
      dv2_num = DIV_W'($signed(m4_sd.negc));
      dv2_den = DIV_W'($signed(m4_sd.a));
    end else if (m4_gen && m4_tgt) begin
      dv2_num = DIV_W'($signed(m4_sd.bmc));
      dv2_den = DIV_W'($signed(m4_sd.a));
    end else begin
      dv2_num = m4_tnum;
      dv2_den = DIV_W'($signed(m4_sd.e)) << SEG_BITS;
    end
    dv2_sd_in.g    = m4_sd.g;
    dv2_sd_in.adeg = m4_sd.adeg;
    dv2_sd_in.edeg = m4_sd.edeg;
    dv2_sd_in.tneg = m4_tneg;
    dv2_sd_in.tgt  = m4_tgt;
    dv2_sd_in.q1   = m4_q;
  end

  sscp_div #(
    .DW     (DIV_W),
    .STEPS  (SEG_BITS),
    .SIDE_W ($bits(tside_t))
  ) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m4_v),
    .num       (dv2_num),
    .den       (dv2_den),
    .side_in   (dv2_sd_in),
    .out_valid (dv2_v),
    .quo       (dv2_q),
    .side_out  (dv2_sd)
  );

  // pick s and t, then form the points
  logic [PARAM_W-1:0] sel_s, sel_t;

  always_comb begin
    if (dv2_sd.adeg && dv2_sd.edeg) begin
      sel_s = '0;
      sel_t = '0;
    end else if (dv2_sd.adeg) begin
      sel_s = '0;
      sel_t = dv2_sd.q1;
    end else if (dv2_sd.edeg) begin
      sel_s = dv2_sd.q1;
      sel_t = '0;
    end else if (dv2_sd.tneg) begin
      sel_s = dv2_q;
      sel_t = '0;
    end else if (dv2_sd.tgt) begin
      sel_s = dv2_q;
      sel_t = PARAM_ONE;
    end else begin
      sel_s = dv2_sd.q1;
      sel_t = dv2_q;
    end
  end

  geom_t                  f1_g, f2_g;
  logic [2:0][PP_W-1:0]   f1_ps, f1_pt;
  logic [2:0][RND_W-1:0]  f2_rs, f2_rt;
  logic                   f1_v, f2_v;
  logic [2:0][PP_W-1:0]   rnd_s, rnd_t;
  logic [2:0][RND_W-1:0]  fin_s, fin_t;

  // round half up, then keep the integer part of the scaled product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_s[i] = f1_ps[i] + (PP_W'(1) << (SEG_BITS - 1));
      rnd_t[i] = f1_pt[i] + (PP_W'(1) << (SEG_BITS - 1));
      fin_s[i] = RND_W'($signed(f2_g.p1[i])) + f2_rs[i];
      fin_t[i] = RND_W'($signed(f2_g.p2[i])) + f2_rt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      done <= 1'b0;
    end else begin
      f1_v <= dv2_v;
      f2_v <= f1_v;
      done <= f2_v;
    end
    f1_g <= dv2_sd.g;
    f2_g <= f1_g;
    for (int i = 0; i < 3; i++) begin
      f1_ps[i] <= mul_pt(dv2_sd.g.d1[i], sel_s);
      f1_pt[i] <= mul_pt(dv2_sd.g.d2[i], sel_t);
      f2_rs[i] <= rnd_s[i][PP_W-1:SEG_BITS];
      f2_rt[i] <= rnd_t[i][PP_W-1:SEG_BITS];
    end
    near_first_x  <= sat_coord(fin_s[0]);
    near_first_y  <= sat_coord(fin_s[1]);
    near_first_z  <= sat_coord(fin_s[2]);
    near_second_x <= sat_coord(fin_t[0]);
    near_second_y <= sat_coord(fin_t[1]);
    near_second_z <= sat_coord(fin_t[2]);
  end

endmodule

FILE: rtl/sscp_checker.sv
// port checker for the segment closest-point pipeline, bound to the top level
module sscp_checker import sscp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // every result word traces back to a word taken a fixed pipeline depth earlier
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result word without a matching input word");

  // no word taken is ever lost
  a_word_delivered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("input word did not produce a result");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result word right after reset");

endmodule

bind segment_segment_closest_points sscp_checker u_sscp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
